@@ sv/rbs_pkg.sv @@
// shared constants and types for the ray/box slab tester
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package rbs_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int DIR_WIDTH       = 16;
    localparam int DIR_FRAC        = 14;
    // quotient bits resolved per divider stage
    localparam int DIV_BITS_PER_STAGE = 4;

    // per-axis side information that travels beside the slab distances
    typedef struct packed {
        logic valid;
        logic zero_dir;
        logic zpass;
    } rbs_flags_t;

endpackage

`default_nettype wire

@@ sv/rbs_div.sv @@
// pipelined unsigned restoring divider, a few quotient bits per stage
// uses rbs_pkg; carries a valid bit and a small tag alongside each beat
`timescale 1ns / 1ps
`default_nettype none

module rbs_div #(
    parameter int NW  = 47,
    parameter int DW  = rbs_pkg::DIR_WIDTH,
    parameter int TW  = 1,
    parameter int BPS = rbs_pkg::DIV_BITS_PER_STAGE
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_vld,
    input  logic [NW-1:0] in_num,
    input  logic [DW-1:0] in_den,
    input  logic [TW-1:0] in_tag,
    output logic          out_vld,
    output logic [NW-1:0] out_quo,
    output logic [TW-1:0] out_tag
);
    import rbs_pkg::*;

    localparam int STAGES = (NW + BPS - 1) / BPS;
    localparam int NP     = STAGES * BPS;

    // dividend bits shift out at the top while quotient bits shift in below
    logic [NP-1:0] num_reg [STAGES];
    logic [DW-1:0] rem_reg [STAGES];
    logic [DW-1:0] den_reg [STAGES];
    logic [TW-1:0] tag_reg [STAGES];
    logic          vld_reg [STAGES];

    genvar s;
    generate
        for (s = 0; s < STAGES; s++) begin : g_stage
            logic [NP-1:0] n_in;
            logic [DW-1:0] r_in;
            logic [DW-1:0] d_in;
            logic [TW-1:0] t_in;
            logic          v_in;
            logic [NP-1:0] n_next;
            logic [DW-1:0] r_next;

            if (s == 0) begin : g_first
                assign n_in = NP'(in_num);
                assign r_in = '0;
                assign d_in = in_den;
                assign t_in = in_tag;
                assign v_in = in_vld;
            end else begin : g_rest
                assign n_in = num_reg[s-1];
                assign r_in = rem_reg[s-1];
                assign d_in = den_reg[s-1];
                assign t_in = tag_reg[s-1];
                assign v_in = vld_reg[s-1];
            end

            always_comb
            begin : p_step
                logic [DW:0] trial;
                n_next = n_in;
                r_next = r_in;
                for (int k = 0; k < BPS; k++)
                begin
                    trial  = {r_next, n_next[NP-1]};
                    n_next = {n_next[NP-2:0], 1'b0};
                    if (trial >= {1'b0, d_in})
                    begin
                        r_next    = DW'(trial - {1'b0, d_in});
                        n_next[0] = 1'b1;
                    end
                    else
                    begin
                        r_next = trial[DW-1:0];
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[s] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[s] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    num_reg[s] <= n_next;
                    rem_reg[s] <= r_next;
                    den_reg[s] <= d_in;
                    tag_reg[s] <= t_in;
                end
            end
        end
    endgenerate

    assign out_vld = vld_reg[STAGES-1];
    assign out_quo = num_reg[STAGES-1][NW-1:0];
    assign out_tag = tag_reg[STAGES-1];

endmodule

`default_nettype wire

@@ sv/rbs_slab.sv @@
// one axis of the slab test: bound-origin distances, two dividers, sign and order
// uses rbs_pkg and rbs_div
`timescale 1ns / 1ps
`default_nettype none

module rbs_slab #(
    parameter int CW = rbs_pkg::COORD_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_vld,
    input  logic signed [CW-1:0]         lo,
    input  logic signed [CW-1:0]         hi,
    input  logic signed [CW-1:0]         org,
    input  logic signed [rbs_pkg::DIR_WIDTH-1:0] dir,
    output rbs_pkg::rbs_flags_t          flags,
    output logic signed [CW-1:0]         near_t,
    output logic signed [CW-1:0]         far_t
);
    import rbs_pkg::*;

    localparam int NW = CW + 1 + DIR_FRAC;
    localparam logic signed [CW-1:0] T_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] T_MIN = {1'b1, {(CW-1){1'b0}}};

    // front stage
    logic signed [CW:0] dlo, dhi;
    logic [CW:0]        mag_lo, mag_hi;
    logic [DIR_WIDTH-1:0] dmag;
    logic signed [CW-1:0] bmin, bmax;

    logic [NW-1:0]        num_lo_reg, num_hi_reg;
    logic [DIR_WIDTH-1:0] den_reg;
    logic                 neg_lo_reg, neg_hi_reg, zero_reg, zpass_reg, vld_reg;

    assign dlo    = {lo[CW-1], lo} - {org[CW-1], org};
    assign dhi    = {hi[CW-1], hi} - {org[CW-1], org};
    assign mag_lo = dlo[CW] ? (CW+1)'(-dlo) : dlo;
    assign mag_hi = dhi[CW] ? (CW+1)'(-dhi) : dhi;
    assign dmag   = dir[DIR_WIDTH-1] ? DIR_WIDTH'(-dir) : dir;
    assign bmin   = (lo < hi) ? lo : hi;
    assign bmax   = (lo < hi) ? hi : lo;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_lo_reg <= {mag_lo, {DIR_FRAC{1'b0}}};
            num_hi_reg <= {mag_hi, {DIR_FRAC{1'b0}}};
            den_reg    <= dmag;
            neg_lo_reg <= dlo[CW] ^ dir[DIR_WIDTH-1];
            neg_hi_reg <= dhi[CW] ^ dir[DIR_WIDTH-1];
            zero_reg   <= (dir == '0);
            zpass_reg  <= !(org < bmin || org > bmax);
        end
    end

    // dividers
    logic          dv_lo_vld, dv_hi_vld;
    logic [NW-1:0] q_lo, q_hi;
    logic [2:0]    tag_lo;
    logic [0:0]    tag_hi;

    rbs_div #(.NW(NW), .DW(DIR_WIDTH), .TW(3)) u_div_lo (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (vld_reg),
        .in_num  (num_lo_reg),
        .in_den  (den_reg),
        .in_tag  ({neg_lo_reg, zero_reg, zpass_reg}),
        .out_vld (dv_lo_vld),
        .out_quo (q_lo),
        .out_tag (tag_lo)
    );

    rbs_div #(.NW(NW), .DW(DIR_WIDTH), .TW(1)) u_div_hi (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (vld_reg),
        .in_num  (num_hi_reg),
        .in_den  (den_reg),
        .in_tag  (neg_hi_reg),
        .out_vld (dv_hi_vld),
        .out_quo (q_hi),
        .out_tag (tag_hi)
    );

    // sign, saturate, order
    function automatic logic signed [CW-1:0] sat(input logic [NW-1:0] q, input logic neg);
        logic big;
        big = |q[NW-1:CW-1];
        if (neg)
            sat = big ? T_MIN : CW'(-q[CW-1:0]);
        else
            sat = big ? T_MAX : q[CW-1:0];
    endfunction

    logic signed [CW-1:0] t_lo, t_hi;
    logic signed [CW-1:0] near_reg, far_reg;
    logic                 flag_vld_reg, flag_zero_reg, flag_zpass_reg;

    assign t_lo = sat(q_lo, tag_lo[2]);
    assign t_hi = sat(q_hi, tag_hi[0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            flag_vld_reg <= dv_lo_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flag_zero_reg  <= tag_lo[1];
            flag_zpass_reg <= tag_lo[0];
            near_reg       <= (t_lo > t_hi) ? t_hi : t_lo;
            far_reg        <= (t_lo > t_hi) ? t_lo : t_hi;
        end
    end

    assign flags  = '{valid: flag_vld_reg, zero_dir: flag_zero_reg, zpass: flag_zpass_reg};
    assign near_t = near_reg;
    assign far_t  = far_reg;

    // both dividers see the same beats
    assert property (@(posedge clk) disable iff (!rst_n) dv_lo_vld == dv_hi_vld)
        else $error("slab dividers out of step");

    // ordered pair leaves the axis
    assert property (@(posedge clk) disable iff (!rst_n)
        flag_vld_reg |-> near_reg <= far_reg)
        else $error("slab near exceeds far");

    // a frozen pipeline keeps its distances
    assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(near_reg) && $stable(far_reg))
        else $error("slab output moved during stall");

endmodule

`default_nettype wire

@@ sv/ray_box_slab_intersect.sv @@
// Ray against axis-aligned box by the slab method, fully pipelined. One box/ray
// beat is accepted every cycle unless the output is stalled; each beat yields
// one result. The pipeline is built from the six restoring dividers (four
// quotient bits per stage, ceil((COORD_WIDTH+15)/4) stages) plus one front
// stage, one sign/order stage and two interval stages. Distances are signed
// Q16.16 truncated toward zero and saturated; the extreme values stand for the
// infinities. A miss returns hit = 0 with both distances 0. A stall freezes the
// whole pipeline, so nothing is lost or repeated.
// top level; uses rbs_pkg and rbs_slab
`timescale 1ns / 1ps
`default_nettype none

module ray_box_slab_intersect #(
    parameter int COORD_WIDTH = rbs_pkg::COORD_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [COORD_WIDTH-1:0]        box_min_x,
    input  logic signed [COORD_WIDTH-1:0]        box_min_y,
    input  logic signed [COORD_WIDTH-1:0]        box_min_z,
    input  logic signed [COORD_WIDTH-1:0]        box_max_x,
    input  logic signed [COORD_WIDTH-1:0]        box_max_y,
    input  logic signed [COORD_WIDTH-1:0]        box_max_z,
    input  logic signed [COORD_WIDTH-1:0]        origin_x,
    input  logic signed [COORD_WIDTH-1:0]        origin_y,
    input  logic signed [COORD_WIDTH-1:0]        origin_z,
    input  logic signed [rbs_pkg::DIR_WIDTH-1:0] dir_x,
    input  logic signed [rbs_pkg::DIR_WIDTH-1:0] dir_y,
    input  logic signed [rbs_pkg::DIR_WIDTH-1:0] dir_z,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 hit,
    output logic signed [COORD_WIDTH-1:0]        t_enter,
    output logic signed [COORD_WIDTH-1:0]        t_exit
);
    import rbs_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam logic signed [CW-1:0] T_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] T_MIN = {1'b1, {(CW-1){1'b0}}};

    typedef struct packed {
        logic                 hit;
        logic signed [CW-1:0] te;
        logic signed [CW-1:0] tx;
    } acc_t;

    function automatic acc_t apply(input acc_t a, input rbs_flags_t f,
                                   input logic signed [CW-1:0] nr,
                                   input logic signed [CW-1:0] fr);
        acc_t r;
        r = a;
        if (!a.hit)
            r = a;
        else if (f.zero_dir)
            r.hit = f.zpass;
        else if (nr > a.tx || a.te > fr)
            r.hit = 1'b0;
        else
        begin
            if (nr > a.te)
                r.te = nr;
            if (fr < a.tx)
                r.tx = fr;
        end
        return r;
    endfunction

    logic en;
    logic out_valid_reg;

    // whole pipeline advances unless the output beat is held
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    rbs_flags_t           fx, fy, fz;
    logic signed [CW-1:0] nx, xf, ny, yf, nz, zf;

    rbs_slab #(.CW(CW)) u_slab_x (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(in_valid),
        .lo(box_min_x), .hi(box_max_x), .org(origin_x), .dir(dir_x),
        .flags(fx), .near_t(nx), .far_t(xf)
    );

    rbs_slab #(.CW(CW)) u_slab_y (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(in_valid),
        .lo(box_min_y), .hi(box_max_y), .org(origin_y), .dir(dir_y),
        .flags(fy), .near_t(ny), .far_t(yf)
    );

    rbs_slab #(.CW(CW)) u_slab_z (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(in_valid),
        .lo(box_min_z), .hi(box_max_z), .org(origin_z), .dir(dir_z),
        .flags(fz), .near_t(nz), .far_t(zf)
    );

    // interval stage one: x then y
    acc_t                 acc_init, acc_x, acc_xy, acc_xyz;
    acc_t                 c1_acc_reg;
    logic                 c1_valid_reg;
    rbs_flags_t           z_flags_reg;
    logic signed [CW-1:0] z_near_reg, z_far_reg;

    assign acc_init = '{hit: 1'b1, te: T_MIN, tx: T_MAX};
    assign acc_x    = apply(acc_init, fx, nx, xf);
    assign acc_xy   = apply(acc_x, fy, ny, yf);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            c1_valid_reg <= fx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_acc_reg  <= acc_xy;
            z_flags_reg <= fz;
            z_near_reg  <= nz;
            z_far_reg   <= zf;
        end
    end

    // interval stage two: z, then the output register
    logic                 hit_reg;
    logic signed [CW-1:0] t_enter_reg, t_exit_reg;

    assign acc_xyz = apply(c1_acc_reg, z_flags_reg, z_near_reg, z_far_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= c1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg     <= acc_xyz.hit;
            t_enter_reg <= acc_xyz.hit ? acc_xyz.te : '0;
            t_exit_reg  <= acc_xyz.hit ? acc_xyz.tx : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign t_enter   = t_enter_reg;
    assign t_exit    = t_exit_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        fx.valid == fy.valid && fy.valid == fz.valid)
        else $error("axis pipelines out of step");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !hit_reg |-> t_enter_reg == '0 && t_exit_reg == '0)
        else $error("miss with nonzero distances");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && hit_reg |-> t_enter_reg <= t_exit_reg)
        else $error("entry beyond exit on a hit");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> $stable(c1_acc_reg) && $stable(c1_valid_reg))
        else $error("interval stage moved during stall");

endmodule

`default_nettype wire
